/* rtl/thermocouple_temperature_convert_unit_assert.svh */
// ============================================================================
// Assertion macros for the thermocouple temperature converter
// Shared concurrent checks, clocked on clock and disabled while in reset.
// ============================================================================
`ifndef THERMOCOUPLE_TEMPERATURE_CONVERT_UNIT_ASSERT_SVH
`define THERMOCOUPLE_TEMPERATURE_CONVERT_UNIT_ASSERT_SVH

// Check that cond_c holds in the same cycle as cond_a
`define TCVT_ASSERT_IMPLIES(lbl, cond_a, cond_c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_c)) \
      else $error("tcvt assertion failed");

// Check that cond_c holds in the cycle after cond_a
`define TCVT_ASSERT_NEXT(lbl, cond_a, cond_c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_c)) \
      else $error("tcvt assertion failed");

`endif

/* rtl/tcvt_pkg.sv */
// ============================================================================
// tcvt_pkg
// Shared constants, types and the type-K characteristic ROM.
// ============================================================================
package tcvt_pkg;

   // Default configuration
   localparam int RING_DEPTH_DEF    = 16;
   localparam int TABLE_ENTRIES_DEF = 54;
   localparam int SAMPLE_BITS_DEF   = 10;

   // Fixed field widths
   localparam int TEMP_W = 16;
   localparam int CJ_W   = 12;
   localparam int FRAC_W = 11;
   localparam int THR_W  = 8;

   // ROM size
   localparam int KTAB_ROM   = 54;
   localparam int KTAB_IDX_W = $clog2(KTAB_ROM);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Division by ten: q = (x * 52429) >> 19, exact for x below 2^16
   localparam int DIV10_MUL_W = 17;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 17'd52429;
   localparam int DIV10_SHIFT = 19;

   // Commands
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_LOW  = 2'd1;
   localparam logic [THR_W-1:0] ALARM_HIGH_RST = 8'd75;
   localparam logic [THR_W-1:0] ALARM_LOW_RST  = 8'd70;

   // Per-request control carried through the queue
   typedef struct packed {
      logic                   cmd;
      logic                   tenth;
      logic signed [CJ_W-1:0] cj;
   } item_ctl_type;

   // Type-K characteristic, 1/16 degree per mV step
   function automatic logic signed [TEMP_W-1:0] ktab_entry(input logic [KTAB_IDX_W-1:0] idx);
      logic signed [TEMP_W-1:0] val;
      case (idx)
         6'd0:  val = 16'sd0;     6'd1:  val = 16'sd386;   6'd2:  val = 16'sd777;
         6'd3:  val = 16'sd1164;  6'd4:  val = 16'sd1549;  6'd5:  val = 16'sd1938;
         6'd6:  val = 16'sd2331;  6'd7:  val = 16'sd2730;  6'd8:  val = 16'sd3130;
         6'd9:  val = 16'sd3530;  6'd10: val = 16'sd3926;  6'd11: val = 16'sd4318;
         6'd12: val = 16'sd4706;  6'd13: val = 16'sd5091;  6'd14: val = 16'sd5475;
         6'd15: val = 16'sd5856;  6'd16: val = 16'sd6236;  6'd17: val = 16'sd6615;
         6'd18: val = 16'sd6992;  6'd19: val = 16'sd7369;  6'd20: val = 16'sd7745;
         6'd21: val = 16'sd8120;  6'd22: val = 16'sd8496;  6'd23: val = 16'sd8871;
         6'd24: val = 16'sd9246;  6'd25: val = 16'sd9622;  6'd26: val = 16'sd9999;
         6'd27: val = 16'sd10377; 6'd28: val = 16'sd10757; 6'd29: val = 16'sd11137;
         6'd30: val = 16'sd11520; 6'd31: val = 16'sd11904; 6'd32: val = 16'sd12290;
         6'd33: val = 16'sd12679; 6'd34: val = 16'sd13070; 6'd35: val = 16'sd13463;
         6'd36: val = 16'sd13858; 6'd37: val = 16'sd14256; 6'd38: val = 16'sd14656;
         6'd39: val = 16'sd15059; 6'd40: val = 16'sd15464; 6'd41: val = 16'sd15872;
         6'd42: val = 16'sd16283; 6'd43: val = 16'sd16697; 6'd44: val = 16'sd17115;
         6'd45: val = 16'sd17535; 6'd46: val = 16'sd17959; 6'd47: val = 16'sd18387;
         6'd48: val = 16'sd18819; 6'd49: val = 16'sd19256; 6'd50: val = 16'sd19697;
         6'd51: val = 16'sd20144; 6'd52: val = 16'sd20597; 6'd53: val = 16'sd21055;
         default: val = 16'sd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/tcvt_front.sv */
// ============================================================================
// tcvt_front
// Request intake: decodes the command and queues requests for the back end.
// ============================================================================
`include "thermocouple_temperature_convert_unit_assert.svh"

module tcvt_front import tcvt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic signed [CJ_W-1:0] req_cj,
   input  logic                   req_tenth,
   // queue head toward the back end
   output logic                   q_valid,
   input  logic                   q_pop,
   output logic [SAMPLE_BITS-1:0] q_sample,
   output item_ctl_type           q_ctl
);

   logic [SAMPLE_BITS-1:0] sample_mem [QUEUE_DEPTH];
   item_ctl_type           ctl_mem    [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff,  count_in;
   logic                   push;
   item_ctl_type           ctl_dec;

   // Classify the request
   always_comb begin
      ctl_dec.cmd   = (req_cmd == CMD_CONVERT) ? CMD_CONVERT : CMD_SAMPLE;
      ctl_dec.tenth = req_tenth;
      ctl_dec.cj    = req_cj;
   end

   assign req_ready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_sample  = sample_mem[rd_ptr_ff];
   assign q_ctl     = ctl_mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (push) begin
         sample_mem[wr_ptr_ff] <= req_sample;
         ctl_mem[wr_ptr_ff]    <= ctl_dec;
      end
   end

   `TCVT_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `TCVT_ASSERT_NEXT(a_count_up, !reset && push && !q_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

/* rtl/tcvt_back.sv */
// ============================================================================
// tcvt_back
// Execution pipeline: sample ring, running sum, table interpolation,
// cold-junction add, divide by ten in tenth mode and alarm compare.
// ============================================================================
`include "thermocouple_temperature_convert_unit_assert.svh"

module tcvt_back import tcvt_pkg::*; #(
   parameter int RING_DEPTH    = RING_DEPTH_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // queue head
   input  logic                     q_valid,
   output logic                     q_pop,
   input  logic [SAMPLE_BITS-1:0]   q_sample,
   input  item_ctl_type             q_ctl,
   // thresholds
   input  logic [THR_W-1:0]         alarm_high,
   input  logic [THR_W-1:0]         alarm_low,
   // result side
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_alarm
);

   localparam int POS_W     = $clog2(RING_DEPTH);
   localparam int SUM_W     = SAMPLE_BITS + POS_W;
   localparam int P_W       = SUM_W + 3;
   localparam int IV_W      = P_W - FRAC_W;
   localparam int KTAB_USED = (TABLE_ENTRIES < KTAB_ROM) ? TABLE_ENTRIES : KTAB_ROM;
   localparam int LAST_IDX  = KTAB_USED - 1;
   localparam int PROD_W    = TEMP_W + FRAC_W;
   localparam int MAG_W     = TEMP_W + 1;
   localparam int P10_W     = MAG_W + DIV10_MUL_W;

   logic adv, take_sample;

   // Ring storage
   logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]  ring_valid_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   // Stage 1: ring read
   logic                   s1_valid_ff;
   logic                   s1_cmd_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [SAMPLE_BITS-1:0] s1_old_ff;
   logic                   s1_oldv_ff;
   logic signed [CJ_W-1:0] s1_cj_ff;
   logic                   s1_tenth_ff;

   // Stage 2: table lookup
   logic [SAMPLE_BITS-1:0]   old_eff;
   logic [P_W-1:0]           volt;
   logic [IV_W-1:0]          iv;
   logic                     past_end;
   logic [KTAB_IDX_W-1:0]    idx0;
   logic signed [TEMP_W-1:0] t0_lk, t1_lk;
   logic                     s2_valid_ff;
   logic signed [TEMP_W-1:0] s2_t0_ff;
   logic [TEMP_W-1:0]        s2_diff_ff;
   logic [FRAC_W-1:0]        s2_frac_ff;
   logic signed [CJ_W-1:0]   s2_cj_ff;
   logic                     s2_tenth_ff;

   // Stage 3: interpolation product
   logic                     s3_valid_ff;
   logic [PROD_W-1:0]        s3_prod_ff;
   logic signed [TEMP_W-1:0] s3_t0_ff;
   logic signed [CJ_W-1:0]   s3_cj_ff;
   logic                     s3_tenth_ff;

   // Stage 4: compensated temperature
   logic [TEMP_W-1:0]        t_sum;
   logic                     s4_valid_ff;
   logic signed [TEMP_W-1:0] s4_t_ff;
   logic                     s4_tenth_ff;

   // Stage 5: reciprocal multiply
   logic [MAG_W-1:0]         t_ext, t_mag;
   logic                     s5_valid_ff;
   logic [P10_W-1:0]         s5_p10_ff;
   logic                     s5_neg_ff;
   logic signed [TEMP_W-1:0] s5_t_ff;
   logic                     s5_tenth_ff;

   // Output stage
   logic [TEMP_W-1:0]        quot, quot_s, t_fin;
   logic signed [11:0]       whole, thr_hi, thr_lo;
   logic                     alarm_in;
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic                     rsp_alarm_ff;

   // Move the whole pipeline when the output register can take a result
   assign adv         = !rsp_valid_ff || rsp_ready;
   assign q_pop       = adv && q_valid;
   assign take_sample = q_pop && (q_ctl.cmd == CMD_SAMPLE);

   // Ring write with read-before-write of the slot being replaced
   always_ff @(posedge clock) begin
      if (take_sample) begin
         ring_mem[pos_ff] <= q_sample;
      end
      if (adv) begin
         s1_old_ff <= ring_mem[pos_ff];
      end
   end

   assign pos_in = (pos_ff == POS_W'(RING_DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         pos_ff        <= '0;
      end else if (take_sample) begin
         ring_valid_ff[pos_ff] <= 1'b1;
         pos_ff                <= pos_in;
      end
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff    <= q_ctl.cmd;
         s1_sample_ff <= q_sample;
         s1_oldv_ff   <= ring_valid_ff[pos_ff];
         s1_cj_ff     <= q_ctl.cj;
         s1_tenth_ff  <= q_ctl.tenth;
      end
   end

   // Update the running sum; unwritten slots count as zero
   assign old_eff = s1_oldv_ff ? s1_old_ff : '0;
   assign sum_in  = sum_ff - SUM_W'(old_eff) + SUM_W'(s1_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (adv && s1_valid_ff && (s1_cmd_ff == CMD_SAMPLE)) begin
         sum_ff <= sum_in;
      end
   end

   // Voltage as sum*7 with 11 fraction bits, then table pair lookup
   always_comb begin
      volt     = {sum_ff, 3'b000} - {3'b000, sum_ff};
      iv       = volt[P_W-1:FRAC_W];
      past_end = (32'(iv) >= 32'(LAST_IDX));
      idx0     = past_end ? KTAB_IDX_W'(LAST_IDX) : KTAB_IDX_W'(iv);
      t0_lk    = ktab_entry(idx0);
      t1_lk    = past_end ? t0_lk : ktab_entry(idx0 + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && (s1_cmd_ff == CMD_CONVERT);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_t0_ff    <= t0_lk;
         s2_diff_ff  <= t1_lk - t0_lk;
         s2_frac_ff  <= volt[FRAC_W-1:0];
         s2_cj_ff    <= s1_cj_ff;
         s2_tenth_ff <= s1_tenth_ff;
      end
   end

   // Interpolation product
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_prod_ff  <= PROD_W'(s2_diff_ff) * PROD_W'(s2_frac_ff);
         s3_t0_ff    <= s2_t0_ff;
         s3_cj_ff    <= s2_cj_ff;
         s3_tenth_ff <= s2_tenth_ff;
      end
   end

   // Add interpolated step and sign-extended cold junction
   assign t_sum = s3_t0_ff + s3_prod_ff[PROD_W-1:FRAC_W]
                + {{(TEMP_W-CJ_W){s3_cj_ff[CJ_W-1]}}, s3_cj_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_t_ff     <= t_sum;
         s4_tenth_ff <= s3_tenth_ff;
      end
   end

   // Magnitude times reciprocal of ten
   assign t_ext = {s4_t_ff[TEMP_W-1], s4_t_ff};
   assign t_mag = s4_t_ff[TEMP_W-1] ? (MAG_W'(0) - t_ext) : t_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_p10_ff   <= P10_W'(t_mag) * P10_W'(DIV10_MUL);
         s5_neg_ff   <= s4_t_ff[TEMP_W-1];
         s5_t_ff     <= s4_t_ff;
         s5_tenth_ff <= s4_tenth_ff;
      end
   end

   // Restore sign, select mode, compare whole degrees
   always_comb begin
      quot     = TEMP_W'(s5_p10_ff >> DIV10_SHIFT);
      quot_s   = s5_neg_ff ? (TEMP_W'(0) - quot) : quot;
      t_fin    = s5_tenth_ff ? quot_s : s5_t_ff;
      whole    = t_fin[TEMP_W-1:4];
      thr_hi   = {4'b0000, alarm_high};
      thr_lo   = {4'b0000, alarm_low};
      alarm_in = (whole > thr_hi) || (whole <= thr_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_temp_ff  <= t_fin;
         rsp_alarm_ff <= alarm_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_alarm       = rsp_alarm_ff;

   `TCVT_ASSERT_NEXT(a_pos_moves, !reset && take_sample, pos_ff != $past(pos_ff))
   `TCVT_ASSERT_NEXT(a_conv_reaches_out, !reset && adv && s5_valid_ff, rsp_valid_ff)

endmodule

/* rtl/thermocouple_temperature_convert_unit.sv */
// ============================================================================
// thermocouple_temperature_convert_unit
// Type-K thermocouple linearization with cold-junction compensation.
// ============================================================================
// The block takes one request per clock while the result side keeps up and
// returns one result per convert request, in order. Sample requests (tuser 0)
// enter the ADC ring and update the running sum; convert requests (tuser 1)
// return the compensated temperature and alarm flag. A four-entry queue sits
// in front of a six-stage execution pipeline that moves as a unit whenever
// its output register is free. The ring uses per-entry valid bits cleared
// at reset, so there is no clearing pass. Threshold registers are written
// through the csr port, always ready; the user must write them only while
// the block is idle, and the block itself does not enforce this.
`include "thermocouple_temperature_convert_unit_assert.svh"

module thermocouple_temperature_convert_unit import tcvt_pkg::*; #(
   parameter int RING_DEPTH    = RING_DEPTH_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   localparam int REQ_DATA_W   = ((SAMPLE_BITS + CJ_W + 1 + 7) / 8) * 8,
   localparam int RSP_DATA_W   = ((TEMP_W + 1 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // adc_sample, cold_junction_raw, tenth_mode (from bit 0 up), zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic                   req_tuser,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // temperature, alarm (from bit 0 up), zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_W-1:0]       csr_wdata
);

   logic [THR_W-1:0]         alarm_high_ff;
   logic [THR_W-1:0]         alarm_low_ff;
   logic                     q_valid, q_pop;
   logic [SAMPLE_BITS-1:0]   q_sample;
   item_ctl_type             q_ctl;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                     rsp_alarm;

   // Threshold registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_high_ff <= ALARM_HIGH_RST;
         alarm_low_ff  <= ALARM_LOW_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALARM_HIGH: alarm_high_ff <= csr_wdata;
            CSR_ALARM_LOW:  alarm_low_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tcvt_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_cj     (req_tdata[SAMPLE_BITS+CJ_W-1:SAMPLE_BITS]),
      .req_tenth  (req_tdata[SAMPLE_BITS+CJ_W]),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_sample   (q_sample),
      .q_ctl      (q_ctl)
   );

   tcvt_back #(
      .RING_DEPTH    (RING_DEPTH),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_sample        (q_sample),
      .q_ctl           (q_ctl),
      .alarm_high      (alarm_high_ff),
      .alarm_low       (alarm_low_ff),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_temperature (rsp_temperature),
      .rsp_alarm       (rsp_alarm)
   );

   // Pack the result
   assign rsp_tdata = RSP_DATA_W'({rsp_alarm, rsp_temperature});

endmodule
